// ===== design/sspg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sspg_pkg;

  localparam int SPD_W = 16;
  localparam int IV_W  = 20;
  localparam int GAP_W = 20;
  localparam int PW_W  = 10;
  localparam int IND_W = 20;
  localparam int CFG_W = 10;
  localparam int IDX_W = 3;
  localparam int OUT_W = 4;

  localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_PULSE_WIDTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_LED_HOLD    = 3'd1;
  localparam logic [IDX_W-1:0] REG_ENABLE_LVL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_PULSE_LVL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LED_PRESENT = 3'd4;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_SPEED = 1'b1;

  typedef struct packed {
    logic signed [SPD_W-1:0] speed;
    logic [IV_W-1:0]         interval;
  } spd_entry_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap;
    logic [PW_W-1:0]  pulse_left;
  } run_entry_t;

endpackage

`default_nettype wire

// ===== design/sspg_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspg_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int W     = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [W-1:0] rd_q;
  logic rd_vld;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// ===== design/sspg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspg_div
  import sspg_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SPD_W-1:0] divisor,
  output logic                  done,
  output logic      [IV_W-1:0]  quotient
);

  localparam int CW = $clog2(IV_W + 1);
  localparam logic [IV_W-1:0] DIVIDEND = IV_W'(TICKS_PER_SECOND);

  logic busy;
  logic [CW-1:0] cnt;
  logic [IV_W-1:0] dq;
  logic [SPD_W-1:0] rem;
  logic [SPD_W-1:0] dvs;
  logic [SPD_W:0] rem_sh;
  logic [SPD_W:0] rem_sub;
  logic qbit;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem, dq[IV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign qbit    = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == CW'(IV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq <= DIVIDEND;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq <= {dq[IV_W-2:0], qbit};
      rem <= qbit ? rem_sub[SPD_W-1:0] : rem_sh[SPD_W-1:0];
    end
  end

  assign quotient = dq;

endmodule

`default_nettype wire

// ===== design/stepper_step_dir_pulse_generator.sv =====
// Step/direction generator for MOTORS stepper motors. Each accepted item
// returns one result with the enable, direction and step line levels of
// motors 0..3 and the shared indicator. A set-speed item for a motor below
// MOTORS runs a shared one-bit-per-cycle divider (TICKS_PER_SECOND / |speed|);
// a tick item sweeps the per-motor state memories at one motor per clock.
// Items are handled one at a time. The result register lets the next item
// enter while a result waits. The state memories need no clearing pass.
// Configuration is taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_dir_pulse_generator
  import sspg_pkg::*;
#(
  parameter int MOTORS = 4,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire logic                    kind,
  input  wire logic [1:0]              motor,
  input  wire logic signed [SPD_W-1:0] speed,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic      [OUT_W-1:0]        enable_lines,
  output logic      [OUT_W-1:0]        direction_lines,
  output logic      [OUT_W-1:0]        pulse_lines,
  output logic                         indicator
);

  localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam logic [IND_W-1:0] TICKS_PER_MS = IND_W'(TICKS_PER_SECOND / 1000);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [PW_W-1:0] pulse_width;
  logic [CFG_W-1:0] led_hold;
  logic en_lvl;
  logic pul_lvl;
  logic led_on;

  logic [MOTORS-1:0] en_q;
  logic [MOTORS-1:0] fwd_q;
  logic [MOTORS-1:0] pls_q;
  logic [IND_W-1:0] ind_left;
  logic [AW-1:0] cnt;
  logic [AW-1:0] set_addr;
  logic signed [SPD_W-1:0] spd_hold;

  logic accept;
  logic motor_ok;
  logic [AW+1:0] motor_ext;
  logic [SPD_W-1:0] mag;
  logic div_start;
  logic div_done;
  logic [IV_W-1:0] quotient;
  logic last;

  logic [AW-1:0] raddr;
  spd_entry_t spd_rd;
  spd_entry_t spd_wr;
  run_entry_t run_rd;
  run_entry_t run_wr;
  logic spd_we;
  logic run_we;

  logic [PW_W-1:0] pw_eff;
  logic [IV_W-1:0] pw_p1;
  logic [IV_W-1:0] iv;
  logic [GAP_W-1:0] gap_base;
  logic [GAP_W-1:0] gap_inc;
  logic [PW_W-1:0] pl_dec;
  logic en_n;
  logic fwd_n;
  logic fwd_cur;
  logic start_pulse;
  logic [29:0] hold_prod;
  logic [IND_W-1:0] hold_ticks;

  logic [OUT_W-1:0] en_c;
  logic [OUT_W-1:0] dir_c;
  logic [OUT_W-1:0] pul_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width <= PW_W'(10);
      led_hold <= CFG_W'(50);
      en_lvl <= 1'b0;
      pul_lvl <= 1'b1;
      led_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PULSE_WIDTH: pulse_width <= cfg_data[PW_W-1:0];
        REG_LED_HOLD:    led_hold <= cfg_data;
        REG_ENABLE_LVL:  en_lvl <= cfg_data[0];
        REG_PULSE_LVL:   pul_lvl <= cfg_data[0];
        REG_LED_PRESENT: led_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item_stall = (state != S_IDLE);
  assign accept = item_valid && !item_stall;
  assign motor_ext = (AW + 2)'(motor);
  assign motor_ok = (int'(motor) < MOTORS);
  assign mag = speed[SPD_W-1] ? SPD_W'(-speed) : SPD_W'(speed);
  assign div_start = accept && (kind == KIND_SPEED) && motor_ok;
  assign last = (cnt == AW'(MOTORS - 1));

  sspg_div #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .divisor(mag),
    .done(div_done),
    .quotient(quotient)
  );

  assign raddr = (state == S_SWEEP && !last) ? cnt + 1'b1 : '0;
  assign spd_we = (state == S_DIV) && div_done;
  assign spd_wr = '{speed: spd_hold, interval: quotient};
  assign run_we = (state == S_SWEEP);

  sspg_mem #(
    .DEPTH(MOTORS),
    .AW(AW),
    .W($bits(spd_entry_t))
  ) u_spd_mem (
    .clk(clk),
    .rst(rst),
    .we(spd_we),
    .waddr(set_addr),
    .wdata(spd_wr),
    .raddr(raddr),
    .rdata(spd_rd)
  );

  sspg_mem #(
    .DEPTH(MOTORS),
    .AW(AW),
    .W($bits(run_entry_t))
  ) u_run_mem (
    .clk(clk),
    .rst(rst),
    .we(run_we),
    .waddr(cnt),
    .wdata(run_wr),
    .raddr(raddr),
    .rdata(run_rd)
  );

  // per-motor update for the entry read last cycle
  assign pw_eff = (pulse_width == '0) ? PW_W'(1) : pulse_width;
  assign pw_p1 = IV_W'(pw_eff) + 1'b1;
  assign iv = (spd_rd.interval <= IV_W'(pw_eff)) ? pw_p1 : spd_rd.interval;
  assign fwd_cur = fwd_q[cnt];
  assign pl_dec = run_rd.pulse_left - 1'b1;
  assign hold_prod = 30'(led_hold) * 30'(TICKS_PER_MS);
  assign hold_ticks = hold_prod[IND_W-1:0];

  always_comb begin
    run_wr = run_rd;
    en_n = en_q[cnt];
    fwd_n = fwd_cur;
    start_pulse = 1'b0;
    gap_base = run_rd.gap;
    gap_inc = '0;
    if (run_rd.pulse_left != '0) begin
      run_wr.pulse_left = pl_dec;
      if (pl_dec == '0) begin
        run_wr.gap = '0;
      end
    end else if (spd_rd.speed == '0) begin
      en_n = 1'b0;
      if (run_rd.gap != GAP_MAX) begin
        run_wr.gap = run_rd.gap + 1'b1;
      end
    end else begin
      en_n = 1'b1;
      fwd_n = !spd_rd.speed[SPD_W-1];
      if (fwd_n != fwd_cur) begin
        gap_base = '0;
      end
      gap_inc = (gap_base != GAP_MAX) ? gap_base + 1'b1 : gap_base;
      run_wr.gap = gap_inc;
      if (gap_inc >= iv) begin
        run_wr.pulse_left = pw_eff;
        start_pulse = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_TICK) begin
            state_next = S_SWEEP;
          end else if (motor_ok) begin
            state_next = S_DIV;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_SWEEP: begin
        if (last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      en_q <= '0;
      fwd_q <= '1;
      pls_q <= '0;
      ind_left <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && kind == KIND_TICK) begin
        cnt <= '0;
        if (ind_left != '0) begin
          ind_left <= ind_left - 1'b1;
        end
      end
      if (state == S_SWEEP) begin
        en_q[cnt] <= en_n;
        fwd_q[cnt] <= fwd_n;
        pls_q[cnt] <= (run_wr.pulse_left != '0);
        if (start_pulse && led_on) begin
          ind_left <= hold_ticks;
        end
        if (!last) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (state == S_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_addr <= motor_ext[AW-1:0];
      spd_hold <= speed;
    end
  end

  for (genvar m = 0; m < OUT_W; m++) begin : g_lines
    if (m < MOTORS) begin : g_on
      assign en_c[m]  = en_q[m] ? en_lvl : !en_lvl;
      assign dir_c[m] = fwd_q[m];
      assign pul_c[m] = pls_q[m] ? pul_lvl : !pul_lvl;
    end else begin : g_off
      assign en_c[m]  = 1'b0;
      assign dir_c[m] = 1'b0;
      assign pul_c[m] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || !result_stall)) begin
      enable_lines <= en_c;
      direction_lines <= dir_c;
      pulse_lines <= pul_c;
      indicator <= led_on && (ind_left != '0);
    end
  end

endmodule

`default_nettype wire

// ===== design/sspg_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspg_check
  import sspg_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             cfg_ready,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire logic [OUT_W-1:0] enable_lines,
  input wire logic [OUT_W-1:0] direction_lines,
  input wire logic [OUT_W-1:0] pulse_lines,
  input wire logic             indicator
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("result or stall after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item taken while another is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> !$rose(result_valid))
    else $error("result appeared without processing");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid && $stable(enable_lines)
      && $stable(direction_lines) && $stable(pulse_lines) && $stable(indicator))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind stepper_step_dir_pulse_generator sspg_check u_sspg_check (
  .clk(clk),
  .rst(rst),
  .cfg_ready(cfg_ready),
  .item_valid(item_valid),
  .item_stall(item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .enable_lines(enable_lines),
  .direction_lines(direction_lines),
  .pulse_lines(pulse_lines),
  .indicator(indicator)
);

`default_nettype wire
